/* rtl/core/rgbled_pkg.sv */
`default_nettype none

package rgbled_pkg;

   localparam int COLOUR_BITS_DEF      = 24;
   localparam int SLOT_COUNT_WIDTH_DEF = 10;

   localparam int RGB_BITS    = 24;
   localparam int CHAN_W      = 8;
   localparam int PULSE_W     = 6;
   localparam int RESET_LEN_W = 10;
   localparam int CSR_DATA_W  = 10;
   localparam int CSR_INDEX_W = 2;

   localparam logic FUNC_TICK = 1'b0;
   localparam logic FUNC_LOAD = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_ONE_HIGH   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZERO_HIGH  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIT_PERIOD = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESET_LOW  = 2'd3;

   localparam logic [PULSE_W-1:0]     ONE_HIGH_RST   = 6'd10;
   localparam logic [PULSE_W-1:0]     ZERO_HIGH_RST  = 6'd2;
   localparam logic [PULSE_W-1:0]     BIT_PERIOD_RST = 6'd12;
   localparam logic [RESET_LEN_W-1:0] RESET_LOW_RST  = 10'd500;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_RESET,
      PH_BITS
   } phase_type;

   typedef struct packed {
      logic [PULSE_W-1:0]     one_high;
      logic [PULSE_W-1:0]     zero_high;
      logic [PULSE_W-1:0]     bit_period;
      logic [RESET_LEN_W-1:0] reset_low;
   } cfg_type;

   typedef struct packed {
      logic line_level;
      logic busy;
      logic rejected;
   } result_type;

   typedef struct packed {
      logic busy_now;
   } status_type;

endpackage

`default_nettype wire

/* rtl/core/rgb_led_serial_line_encoder.sv */
`default_nettype none

// channel   direction  handshake              payload
// req       in         req_valid / req_stall  req_func, req_red, req_green, req_blue
// rsp       out        rsp_valid / rsp_stall  rsp_line_level, rsp_busy_res, rsp_load_rejected
// csr       in         csr_wen                csr_index, csr_wdata
//
// one beat per cycle unless req_stall is high: the line state and the result are computed
// in the cycle a beat is taken and the result stands in the output register on the next cycle
// the single output register holds the result until it is taken
// reset clears the line state and the output valid and restores register defaults
// req_stall is high only while a result waits in the output register and rsp_stall is high

module rgb_led_serial_line_encoder #(
   parameter int COLOUR_BITS      = rgbled_pkg::COLOUR_BITS_DEF,
   parameter int SLOT_COUNT_WIDTH = rgbled_pkg::SLOT_COUNT_WIDTH_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output      logic                                  req_stall,
   input  wire logic                                  req_func,
   input  wire logic [rgbled_pkg::CHAN_W-1:0]         req_red,
   input  wire logic [rgbled_pkg::CHAN_W-1:0]         req_green,
   input  wire logic [rgbled_pkg::CHAN_W-1:0]         req_blue,
   output      logic                                  rsp_valid,
   input  wire logic                                  rsp_stall,
   output      logic                                  rsp_line_level,
   output      logic                                  rsp_busy_res,
   output      logic                                  rsp_load_rejected,
   input  wire logic                                  csr_wen,
   input  wire logic [rgbled_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [rgbled_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import rgbled_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   result_type result;
   status_type status;
   result_type rsp_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (csr_index)
            CSR_ONE_HIGH:   cfg_in.one_high   = csr_wdata[PULSE_W-1:0];
            CSR_ZERO_HIGH:  cfg_in.zero_high  = csr_wdata[PULSE_W-1:0];
            CSR_BIT_PERIOD: cfg_in.bit_period = csr_wdata[PULSE_W-1:0];
            CSR_RESET_LOW:  cfg_in.reset_low  = csr_wdata[RESET_LEN_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.one_high   <= ONE_HIGH_RST;
         cfg_ff.zero_high  <= ZERO_HIGH_RST;
         cfg_ff.bit_period <= BIT_PERIOD_RST;
         cfg_ff.reset_low  <= RESET_LOW_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rgbled_engine #(
      .COLOUR_BITS      (COLOUR_BITS),
      .SLOT_COUNT_WIDTH (SLOT_COUNT_WIDTH)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .step   (accept),
      .func   (req_func),
      .rgb    ({req_red, req_green, req_blue}),
      .cfg    (cfg_ff),
      .result (result),
      .status (status)
   );

   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_line_level    = rsp_ff.line_level;
   assign rsp_busy_res      = rsp_ff.busy;
   assign rsp_load_rejected = rsp_ff.rejected;

   // a refused load leaves the transfer running
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.rejected) |-> rsp_ff.busy)
      else $error("rejected load reported with idle line");

   // load taken while idle starts the reset time with the line low
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_func == FUNC_LOAD && !status.busy_now)
      |=> (rsp_valid_ff && rsp_ff.busy && !rsp_ff.line_level && !rsp_ff.rejected))
      else $error("accepted load did not start a transfer");

   // load taken while busy is flagged
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_func == FUNC_LOAD && status.busy_now)
      |=> (rsp_valid_ff && rsp_ff.rejected))
      else $error("load during transfer not flagged");

   // ticks never flag a rejection
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_func == FUNC_TICK) |=> !rsp_ff.rejected)
      else $error("tick beat flagged as rejected");

endmodule

`default_nettype wire

/* rtl/core/rgbled_engine.sv */
`default_nettype none

module rgbled_engine #(
   parameter int COLOUR_BITS      = rgbled_pkg::COLOUR_BITS_DEF,
   parameter int SLOT_COUNT_WIDTH = rgbled_pkg::SLOT_COUNT_WIDTH_DEF
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     step,
   input  wire logic                                     func,
   input  wire logic [rgbled_pkg::RGB_BITS-1:0]          rgb,
   input  wire rgbled_pkg::cfg_type                      cfg,
   output rgbled_pkg::result_type                        result,
   output rgbled_pkg::status_type                        status
);
   import rgbled_pkg::*;

   localparam int BL_W  = $clog2(COLOUR_BITS);
   localparam int CMP_W = ((SLOT_COUNT_WIDTH > RESET_LEN_W) ? SLOT_COUNT_WIDTH : RESET_LEN_W) + 1;
   localparam logic [CMP_W-1:0] SLOT_MAX = CMP_W'({SLOT_COUNT_WIDTH{1'b1}});
   localparam logic [BL_W-1:0]  LAST_BIT = BL_W'(COLOUR_BITS - 1);

   logic [COLOUR_BITS-1:0]      shift_ff, shift_in;
   logic [BL_W-1:0]             bits_left_ff, bits_left_in;
   logic [SLOT_COUNT_WIDTH-1:0] slot_ff, slot_in;
   phase_type                   phase_ff, phase_in;
   logic                        line_ff, line_in;

   logic [COLOUR_BITS-1:0]      colour_load;
   logic [CMP_W-1:0]            next_count;
   logic [CMP_W-1:0]            reset_len;
   logic [CMP_W-1:0]            period_len;
   logic [CMP_W-1:0]            high_len;
   logic                        rejected;

   function automatic logic span_done(input logic [CMP_W-1:0] nxt,
                                      input logic [CMP_W-1:0] len);
      logic [CMP_W-1:0] eff;
      eff = (len == '0) ? CMP_W'(1) : len;
      return (nxt >= eff) || (nxt >= SLOT_MAX);
   endfunction

   always_comb begin
      colour_load  = COLOUR_BITS'(rgb) << (COLOUR_BITS - RGB_BITS);
      next_count   = CMP_W'(slot_ff) + CMP_W'(1);
      reset_len    = CMP_W'(cfg.reset_low);
      period_len   = CMP_W'(cfg.bit_period);
      high_len     = shift_ff[COLOUR_BITS-1] ? CMP_W'(cfg.one_high) : CMP_W'(cfg.zero_high);

      shift_in     = shift_ff;
      bits_left_in = bits_left_ff;
      slot_in      = slot_ff;
      phase_in     = phase_ff;
      line_in      = line_ff;
      rejected     = 1'b0;

      if (func == FUNC_LOAD) begin
         if (phase_ff != PH_IDLE) begin
            rejected = 1'b1;
         end else begin
            shift_in     = colour_load;
            bits_left_in = LAST_BIT;
            slot_in      = '0;
            phase_in     = PH_RESET;
            line_in      = 1'b0;
         end
      end else begin
         case (phase_ff)
            PH_RESET: begin
               line_in = 1'b0;
               if (span_done(next_count, reset_len)) begin
                  phase_in = PH_BITS;
                  slot_in  = '0;
               end else begin
                  slot_in = SLOT_COUNT_WIDTH'(next_count);
               end
            end
            PH_BITS: begin
               line_in = (CMP_W'(slot_ff) < high_len);
               if (span_done(next_count, period_len)) begin
                  slot_in  = '0;
                  shift_in = shift_ff << 1;
                  if (bits_left_ff == '0) begin
                     phase_in = PH_IDLE;
                  end else begin
                     bits_left_in = bits_left_ff - BL_W'(1);
                  end
               end else begin
                  slot_in = SLOT_COUNT_WIDTH'(next_count);
               end
            end
            default: begin
               phase_in = PH_IDLE;
               line_in  = 1'b0;
            end
         endcase
      end

      result.line_level = line_in;
      result.busy       = (phase_in != PH_IDLE);
      result.rejected   = rejected;
      status.busy_now   = (phase_ff != PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff     <= '0;
         bits_left_ff <= '0;
         slot_ff      <= '0;
         phase_ff     <= PH_IDLE;
         line_ff      <= 1'b0;
      end else if (step) begin
         shift_ff     <= shift_in;
         bits_left_ff <= bits_left_in;
         slot_ff      <= slot_in;
         phase_ff     <= phase_in;
         line_ff      <= line_in;
      end
   end

endmodule

`default_nettype wire
